@@ hw/rtl/usbhrh_pkg.sv @@
// Shared types and constants for the USB host controller root hub register block.
package usbhrh_pkg;

   // Root hub geometry and frame timing
   localparam int unsigned NUM_PORTS    = 2;
   localparam int unsigned PORT_SLOTS   = 2;
   localparam int unsigned FRAME_TICKS  = 25000;
   localparam int unsigned RESET_FRAMES = 10;

   // Fixed values and masks
   localparam logic [31:0] REVISION_VALUE = 32'h0000_0010;
   localparam logic [31:0] CMD_STAT_MASK  = 32'h0000_000E;
   localparam logic [31:0] COMM_BASE_MASK = 32'hFFFF_FF00;
   localparam logic [31:0] CHANGE_BITS    = 32'h001F_0000;
   localparam logic [31:0] RESET_DONE_BIT = 32'h0010_0000;
   localparam logic [31:0] CONN_CHG_BIT   = 32'h0001_0000;
   localparam logic [31:0] RHSC_BIT       = 32'h0000_0040;
   localparam logic [31:0] SOF_BIT        = 32'h0000_0004;
   localparam logic [31:0] SUSPEND_BITS   = 32'h0000_00C0;
   localparam logic [13:0] FRAME_REM_MASK = 14'h3FFF;
   localparam logic [11:0] LS_THRESH_MASK = 12'hFFF;
   localparam logic [1:0]  FUNC_OPER      = 2'b10;

   // Request commands
   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Register word indexes
   typedef enum logic [5:0] {
      REG_REVISION    = 6'd0,
      REG_CONTROL     = 6'd1,
      REG_CMD_STATUS  = 6'd2,
      REG_INT_STATUS  = 6'd3,
      REG_INT_ENABLE  = 6'd4,
      REG_INT_DISABLE = 6'd5,
      REG_HCCA        = 6'd6,
      REG_PERIOD_CUR  = 6'd7,
      REG_CTRL_HEAD   = 6'd8,
      REG_CTRL_CUR    = 6'd9,
      REG_BULK_HEAD   = 6'd10,
      REG_BULK_CUR    = 6'd11,
      REG_DONE_HEAD   = 6'd12,
      REG_FM_INTERVAL = 6'd13,
      REG_FM_REMAIN   = 6'd14,
      REG_FM_NUMBER   = 6'd15,
      REG_PERIOD_STRT = 6'd16,
      REG_LS_THRESH   = 6'd17,
      REG_RH_DESC_A   = 6'd18,
      REG_RH_DESC_B   = 6'd19,
      REG_RH_STATUS   = 6'd20,
      REG_PORT_BASE   = 6'd21
   } reg_idx_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_PORTS_PRESENT = 2'd0,
      CSR_DESC_A_INIT   = 2'd1,
      CSR_DESC_B_INIT   = 2'd2,
      CSR_UNUSED        = 2'd3
   } csr_idx_type;

   localparam logic [1:0]  PORTS_PRESENT_RST = 2'd1;
   localparam logic [31:0] DESC_A_RST        = 32'd2;
   localparam logic [31:0] DESC_B_RST        = 32'd0;

endpackage

@@ hw/rtl/usb_host_controller_root_hub_regs_unit.sv @@
// Top level: register file and two-port root hub of the USB host controller.

// Each request beat (read, write, frame tick or no-op) is taken and all of its
// register updates are done in that same cycle; its response beat appears on
// the rsp_ channel on the next cycle and is held in a single output register.
// The block accepts one request beat per cycle, every cycle, as long as the
// output register is empty or is being drained in that cycle; the only wide
// path is the 64-bit timebase difference compared with the frame period.
// Configuration writes (ports present, descriptor A/B board values) are taken
// in any cycle outside reset in which no request beat is taken; descriptor
// writes also load the live register.
module usb_host_controller_root_hub_regs_unit
   import usbhrh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [5:0]  req_reg_index,
   input  logic [31:0] req_write_data,
   input  logic [63:0] req_time_now,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_pending,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   // Architectural state
   logic [1:0]  ports_present_ff;
   logic [31:0] hc_control_ff, hc_control_in;
   logic [3:0]  cmd_status_ff, cmd_status_in;
   logic [31:0] int_status_ff, int_status_in;
   logic [31:0] int_enable_ff, int_enable_in;
   logic [31:0] hcca_ff, hcca_in;
   logic [31:0] list_ptr_ff [4];
   logic [31:0] list_ptr_in [4];
   logic [31:0] fm_interval_ff, fm_interval_in;
   logic [15:0] fm_number_ff, fm_number_in;
   logic [13:0] period_start_ff, period_start_in;
   logic [11:0] ls_thresh_ff, ls_thresh_in;
   logic [31:0] desc_a_ff, desc_a_in;
   logic [31:0] desc_b_ff, desc_b_in;
   logic [31:0] port_status_ff [PORT_SLOTS];
   logic [31:0] port_status_in [PORT_SLOTS];
   logic [7:0]  port_rst_cnt_ff [PORT_SLOTS];
   logic [7:0]  port_rst_cnt_in [PORT_SLOTS];
   logic [63:0] last_frame_ff, last_frame_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_irq_ff, rsp_irq_in;

   logic        req_fire;
   logic        csr_fire;
   cmd_type     cmd;
   logic [1:0]  list_sel;
   logic [63:0] elapsed;
   logic        frame_due;

   assign req_ready = ~reset & (~rsp_valid_ff | rsp_ready);
   assign csr_ready = ~reset & ~req_fire;
   assign req_fire  = req_valid & req_ready;
   assign csr_fire  = csr_valid & csr_ready;
   assign cmd       = cmd_type'(req_cmd);
   assign list_sel  = req_reg_index[1:0];
   assign elapsed   = req_time_now - last_frame_ff;
   assign frame_due = elapsed >= 64'(FRAME_TICKS);

   // Read mux plus all register updates for one request beat
   always_comb begin
      logic [31:0] p;
      logic [31:0] prev;
      logic        connected;
      logic [7:0]  cnt;

      hc_control_in   = hc_control_ff;
      cmd_status_in   = cmd_status_ff;
      int_status_in   = int_status_ff;
      int_enable_in   = int_enable_ff;
      hcca_in         = hcca_ff;
      list_ptr_in     = list_ptr_ff;
      fm_interval_in  = fm_interval_ff;
      fm_number_in    = fm_number_ff;
      period_start_in = period_start_ff;
      ls_thresh_in    = ls_thresh_ff;
      desc_a_in       = desc_a_ff;
      desc_b_in       = desc_b_ff;
      port_status_in  = port_status_ff;
      port_rst_cnt_in = port_rst_cnt_ff;
      last_frame_in   = last_frame_ff;
      rsp_data_in     = '0;
      p               = '0;
      prev            = '0;
      connected       = 1'b0;
      cnt             = '0;

      unique case (cmd)
         CMD_READ: begin
            unique case (req_reg_index)
               REG_REVISION:    rsp_data_in = REVISION_VALUE;
               REG_CONTROL:     rsp_data_in = hc_control_ff;
               REG_CMD_STATUS:  rsp_data_in = 32'(cmd_status_ff);
               REG_INT_STATUS:  rsp_data_in = int_status_ff;
               REG_INT_ENABLE,
               REG_INT_DISABLE: rsp_data_in = int_enable_ff;
               REG_HCCA:        rsp_data_in = hcca_ff;
               REG_CTRL_HEAD,
               REG_CTRL_CUR,
               REG_BULK_HEAD,
               REG_BULK_CUR:    rsp_data_in = list_ptr_ff[list_sel];
               REG_FM_INTERVAL: rsp_data_in = fm_interval_ff;
               REG_FM_REMAIN:   rsp_data_in = 32'(fm_interval_ff[13:0] & FRAME_REM_MASK);
               REG_FM_NUMBER:   rsp_data_in = 32'(fm_number_ff);
               REG_PERIOD_STRT: rsp_data_in = 32'(period_start_ff);
               REG_LS_THRESH:   rsp_data_in = 32'(ls_thresh_ff);
               REG_RH_DESC_A:   rsp_data_in = desc_a_ff;
               REG_RH_DESC_B:   rsp_data_in = desc_b_ff;
               default: begin
                  for (int n = 0; n < PORT_SLOTS; n++) begin
                     if (n < NUM_PORTS && req_reg_index == 6'(REG_PORT_BASE + n))
                        rsp_data_in = port_status_ff[n];
                  end
               end
            endcase
         end

         CMD_WRITE: begin
            unique case (req_reg_index)
               REG_CONTROL: hc_control_in = req_write_data;
               REG_CMD_STATUS: begin
                  // soft reset: suspend, clear status/enables/base/frame, keep RHSC if a port change is pending
                  if (req_write_data[0]) begin
                     hc_control_in = hc_control_ff | SUSPEND_BITS;
                     int_status_in = '0;
                     int_enable_in = '0;
                     hcca_in       = '0;
                     fm_number_in  = '0;
                     for (int n = 0; n < PORT_SLOTS; n++) begin
                        if (n < NUM_PORTS && (port_status_ff[n] & CHANGE_BITS) != '0)
                           int_status_in = int_status_in | RHSC_BIT;
                     end
                  end
                  cmd_status_in = 4'(req_write_data & CMD_STAT_MASK);
               end
               REG_INT_STATUS:  int_status_in = int_status_ff & ~req_write_data;
               REG_INT_ENABLE:  int_enable_in = int_enable_ff | req_write_data;
               REG_INT_DISABLE: int_enable_in = int_enable_ff & ~req_write_data;
               REG_HCCA:        hcca_in = req_write_data & COMM_BASE_MASK;
               REG_CTRL_HEAD,
               REG_CTRL_CUR,
               REG_BULK_HEAD,
               REG_BULK_CUR:    list_ptr_in[list_sel] = {req_write_data[31:4], 4'h0};
               REG_FM_INTERVAL: fm_interval_in = req_write_data;
               REG_PERIOD_STRT: period_start_in = req_write_data[13:0] & FRAME_REM_MASK;
               REG_LS_THRESH:   ls_thresh_in = req_write_data[11:0] & LS_THRESH_MASK;
               REG_RH_DESC_A:   desc_a_in = {req_write_data[31:8], desc_a_ff[7:0]};
               REG_RH_DESC_B:   desc_b_in = req_write_data;
               default: begin
                  // root hub port status writes
                  for (int n = 0; n < PORT_SLOTS; n++) begin
                     if (n < NUM_PORTS && req_reg_index == 6'(REG_PORT_BASE + n)) begin
                        p         = port_status_ff[n];
                        prev      = p;
                        connected = ports_present_ff[n];
                        if (req_write_data[8]) p[8] = 1'b1;
                        if (req_write_data[9]) p[8] = 1'b0;
                        if (req_write_data[1]) begin
                           if (connected) p[1] = 1'b1;
                           else p = p | CONN_CHG_BIT;
                        end
                        if (req_write_data[0]) p[1] = 1'b0;
                        if (req_write_data[4]) begin
                           if (connected) begin
                              p[4] = 1'b1;
                              port_rst_cnt_in[n] = 8'(RESET_FRAMES);
                           end else begin
                              p = p | CONN_CHG_BIT;
                           end
                        end
                        p = p & ~(req_write_data & CHANGE_BITS);
                        port_status_in[n] = p;
                        if ((p & ~prev & CHANGE_BITS) != '0)
                           int_status_in = int_status_in | RHSC_BIT;
                     end
                  end
               end
            endcase
         end

         CMD_TICK: begin
            if (frame_due) begin
               last_frame_in = req_time_now;
               // port reset countdown, one step per frame
               for (int n = 0; n < PORT_SLOTS; n++) begin
                  if (n < NUM_PORTS && port_rst_cnt_ff[n] != '0) begin
                     cnt = port_rst_cnt_ff[n] - 8'd1;
                     port_rst_cnt_in[n] = cnt;
                     if (cnt == '0) begin
                        prev = port_status_ff[n];
                        p    = (prev & ~32'h10) | 32'h2 | RESET_DONE_BIT;
                        port_status_in[n] = p;
                        if ((p & ~prev & CHANGE_BITS) != '0)
                           int_status_in = int_status_in | RHSC_BIT;
                     end
                  end
               end
               // frame advance only when operational
               if (hc_control_ff[7:6] == FUNC_OPER) begin
                  fm_number_in  = fm_number_ff + 16'd1;
                  int_status_in = int_status_in | SOF_BIT;
               end
            end
         end

         default: ;
      endcase

      rsp_irq_in = int_enable_in[31] &
                   ((int_status_in & int_enable_in & 32'h7FFF_FFFF) != '0);
   end

   // Response register with stall
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= rsp_irq_in;
      end
   end

   // Register file update
   always_ff @(posedge clock) begin
      if (reset) begin
         ports_present_ff <= PORTS_PRESENT_RST;
         hc_control_ff    <= '0;
         cmd_status_ff    <= '0;
         int_status_ff    <= '0;
         int_enable_ff    <= '0;
         hcca_ff          <= '0;
         for (int i = 0; i < 4; i++) list_ptr_ff[i] <= '0;
         fm_interval_ff   <= '0;
         fm_number_ff     <= '0;
         period_start_ff  <= '0;
         ls_thresh_ff     <= '0;
         desc_a_ff        <= DESC_A_RST;
         desc_b_ff        <= DESC_B_RST;
         for (int n = 0; n < PORT_SLOTS; n++) begin
            port_status_ff[n]  <= '0;
            port_rst_cnt_ff[n] <= '0;
         end
         last_frame_ff    <= '0;
      end else begin
         if (req_fire) begin
            hc_control_ff   <= hc_control_in;
            cmd_status_ff   <= cmd_status_in;
            int_status_ff   <= int_status_in;
            int_enable_ff   <= int_enable_in;
            hcca_ff         <= hcca_in;
            list_ptr_ff     <= list_ptr_in;
            fm_interval_ff  <= fm_interval_in;
            fm_number_ff    <= fm_number_in;
            period_start_ff <= period_start_in;
            ls_thresh_ff    <= ls_thresh_in;
            desc_a_ff       <= desc_a_in;
            desc_b_ff       <= desc_b_in;
            port_status_ff  <= port_status_in;
            port_rst_cnt_ff <= port_rst_cnt_in;
            last_frame_ff   <= last_frame_in;
         end
         // board straps; csr_ready keeps these apart from request beats
         if (csr_fire) begin
            unique case (csr_idx_type'(csr_index))
               CSR_PORTS_PRESENT: ports_present_ff <= csr_write_data[1:0];
               CSR_DESC_A_INIT:   desc_a_ff <= csr_write_data;
               CSR_DESC_B_INIT:   desc_b_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_irq_pending = rsp_irq_ff;

endmodule

@@ hw/rtl/usbhrh_checker.sv @@
// Port-level checker for the root hub register block, with its bind.
module usbhrh_checker
   import usbhrh_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_cmd,
   input logic [5:0]  req_reg_index,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_read_data,
   input logic        rsp_irq_pending
);

   // a stalled response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                  && $stable(rsp_irq_pending))
      else $error("response beat changed while stalled");

   // requests are taken whenever the output register is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with empty output register");

   // every accepted request gives a response beat next cycle
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request without response beat");

   // revision register reads its fixed value
   a_revision: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == CMD_READ && req_reg_index == REG_REVISION
      |=> rsp_read_data == REVISION_VALUE)
      else $error("revision read mismatch");

   // only reads return data
   a_nonread_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != CMD_READ |=> rsp_read_data == '0)
      else $error("non-read beat returned data");

endmodule

bind usb_host_controller_root_hub_regs_unit usbhrh_checker u_usbhrh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_cmd         (req_cmd),
   .req_reg_index   (req_reg_index),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_read_data   (rsp_read_data),
   .rsp_irq_pending (rsp_irq_pending)
);

@@ tb/usb_host_controller_root_hub_regs_unit_tb.sv @@
// Self-checking testbench for the USB host controller root hub register block.
module usb_host_controller_root_hub_regs_unit_tb
   import usbhrh_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // Port register write bits and status bits
   localparam logic [31:0] PORT_CLR_ENABLE = 32'h0000_0001;
   localparam logic [31:0] PORT_ENABLE     = 32'h0000_0002;
   localparam logic [31:0] PORT_RESET      = 32'h0000_0010;
   localparam logic [31:0] PORT_POWER      = 32'h0000_0100;
   localparam logic [31:0] PORT_CLR_POWER  = 32'h0000_0200;
   localparam logic [31:0] PORT_WRITE_BITS = CHANGE_BITS | 32'h0000_0313;
   localparam logic [31:0] LIST_PTR_MASK   = 32'hFFFF_FFF0;
   localparam logic [31:0] IRQ_MASTER      = 32'h8000_0000;
   localparam int unsigned IDLE_PCT        = 36;
   localparam int unsigned HOLD_CYCLES     = 300;

   typedef struct {
      cmd_type     cmd;
      logic [5:0]  idx;
      logic [31:0] wdata;
      logic [63:0] now;
   } hub_req_type;

   typedef struct {
      logic [31:0] read_data;
      logic        irq;
   } hub_rsp_type;

   // DUT signals; the driven inputs are known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_cmd = CMD_NOP;
   logic [5:0]  req_reg_index = '0;
   logic [31:0] req_write_data = '0;
   logic [63:0] req_time_now = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_pending;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_PORTS_PRESENT;
   logic [31:0] csr_write_data = '0;

   // Predicted register file and board setup
   logic [1:0]  hub_ports_present = PORTS_PRESENT_RST;
   logic [31:0] hub_desc_a_init = DESC_A_RST;
   logic [31:0] hub_desc_b_init = DESC_B_RST;
   logic [31:0] hub_control = '0;
   logic [3:0]  hub_cmd_status = '0;
   logic [31:0] hub_int_status = '0;
   logic [31:0] hub_int_enable = '0;
   logic [31:0] hub_hcca = '0;
   logic [31:0] hub_lists [4] = '{default: '0};
   logic [31:0] hub_fm_interval = '0;
   logic [15:0] hub_fm_number = '0;
   logic [13:0] hub_period_start = '0;
   logic [11:0] hub_ls_thresh = '0;
   logic [31:0] hub_desc_a = DESC_A_RST;
   logic [31:0] hub_desc_b = DESC_B_RST;
   logic [31:0] hub_port [PORT_SLOTS] = '{default: '0};
   logic [7:0]  hub_port_rst [PORT_SLOTS] = '{default: '0};
   logic [63:0] hub_last_frame = '0;

   // Stimulus and scoreboard
   hub_req_type pending_q [$];
   hub_rsp_type expected_q [$];
   logic [63:0] tick_base = '0;
   bit          req_taken = 1'b0;
   bit          no_idle = 1'b0;
   int unsigned hold_asked = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned fail_count = 0;
   int unsigned rsp_count = 0;
   int unsigned n_reads = 0;
   int unsigned n_writes = 0;
   int unsigned n_ticks = 0;
   int unsigned n_frames = 0;

   usb_host_controller_root_hub_regs_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_reg_index   (req_reg_index),
      .req_write_data  (req_write_data),
      .req_time_now    (req_time_now),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_irq_pending (rsp_irq_pending),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always #5 clock = ~clock;

   // Any change bit newly set raises root hub status change
   function automatic void flag_change(logic [31:0] was, logic [31:0] now_val);
      if (((now_val & ~was) & CHANGE_BITS) != 0) hub_int_status |= RHSC_BIT;
   endfunction

   // Append one request to the driver's queue
   function automatic void add_pending(hub_req_type q);
      pending_q = {pending_q, q};
   endfunction

   // Apply one request to the predicted register file, return its response
   function automatic hub_rsp_type predict_response(cmd_type cmd, logic [5:0] idx,
                                                    logic [31:0] v, logic [63:0] now);
      hub_rsp_type r;
      logic [31:0] p;
      logic [31:0] was;
      int unsigned n;
      bit          is_port;
      r.read_data = '0;
      is_port = (idx >= REG_PORT_BASE) && (idx < REG_PORT_BASE + NUM_PORTS);
      n = idx - REG_PORT_BASE;
      if (cmd == CMD_READ) begin
         case (idx)
            REG_REVISION:                     r.read_data = REVISION_VALUE;
            REG_CONTROL:                      r.read_data = hub_control;
            REG_CMD_STATUS:                   r.read_data = {28'd0, hub_cmd_status};
            REG_INT_STATUS:                   r.read_data = hub_int_status;
            REG_INT_ENABLE, REG_INT_DISABLE:  r.read_data = hub_int_enable;
            REG_HCCA:                         r.read_data = hub_hcca;
            REG_CTRL_HEAD, REG_CTRL_CUR,
            REG_BULK_HEAD, REG_BULK_CUR:      r.read_data = hub_lists[idx - REG_CTRL_HEAD];
            REG_FM_INTERVAL:                  r.read_data = hub_fm_interval;
            REG_FM_REMAIN:    r.read_data = {18'd0, hub_fm_interval[13:0] & FRAME_REM_MASK};
            REG_FM_NUMBER:                    r.read_data = {16'd0, hub_fm_number};
            REG_PERIOD_STRT:                  r.read_data = {18'd0, hub_period_start};
            REG_LS_THRESH:                    r.read_data = {20'd0, hub_ls_thresh};
            REG_RH_DESC_A:                    r.read_data = hub_desc_a;
            REG_RH_DESC_B:                    r.read_data = hub_desc_b;
            default: if (is_port) r.read_data = hub_port[n];
         endcase
      end else if (cmd == CMD_WRITE) begin
         case (idx)
            REG_CONTROL: hub_control = v;
            REG_CMD_STATUS: begin
               // soft reset: suspend, wipe status/enables/base/frame, keep RHSC if a port change is pending
               if (v[0]) begin
                  hub_control |= SUSPEND_BITS;
                  hub_int_status = '0;
                  hub_int_enable = '0;
                  hub_hcca = '0;
                  hub_fm_number = '0;
                  for (int k = 0; k < NUM_PORTS; k++)
                     if ((hub_port[k] & CHANGE_BITS) != 0) hub_int_status |= RHSC_BIT;
               end
               hub_cmd_status = v[3:0] & CMD_STAT_MASK[3:0];
            end
            REG_INT_STATUS:  hub_int_status &= ~v;
            REG_INT_ENABLE:  hub_int_enable |= v;
            REG_INT_DISABLE: hub_int_enable &= ~v;
            REG_HCCA:        hub_hcca = v & COMM_BASE_MASK;
            REG_CTRL_HEAD, REG_CTRL_CUR,
            REG_BULK_HEAD, REG_BULK_CUR: hub_lists[idx - REG_CTRL_HEAD] = v & LIST_PTR_MASK;
            REG_FM_INTERVAL: hub_fm_interval = v;
            REG_PERIOD_STRT: hub_period_start = v[13:0] & FRAME_REM_MASK;
            REG_LS_THRESH:   hub_ls_thresh = v[11:0] & LS_THRESH_MASK;
            REG_RH_DESC_A:   hub_desc_a = {v[31:8], hub_desc_a[7:0]};
            REG_RH_DESC_B:   hub_desc_b = v;
            default: if (is_port) begin
               // port write; on an empty port, enable and reset set a connect change instead
               p = hub_port[n];
               was = p;
               if ((v & PORT_POWER) != 0) p |= PORT_POWER;
               if ((v & PORT_CLR_POWER) != 0) p &= ~PORT_POWER;
               if ((v & PORT_ENABLE) != 0) p |= hub_ports_present[n] ? PORT_ENABLE : CONN_CHG_BIT;
               if ((v & PORT_CLR_ENABLE) != 0) p &= ~PORT_ENABLE;
               if ((v & PORT_RESET) != 0) begin
                  if (hub_ports_present[n]) begin
                     p |= PORT_RESET;
                     hub_port_rst[n] = RESET_FRAMES[7:0];
                  end else begin
                     p |= CONN_CHG_BIT;
                  end
               end
               p &= ~(v & CHANGE_BITS);
               hub_port[n] = p;
               flag_change(was, p);
            end
         endcase
      end else if (cmd == CMD_TICK) begin
         // early ticks are dropped; wrapping difference
         if (now - hub_last_frame >= 64'(FRAME_TICKS)) begin
            hub_last_frame = now;
            n_frames++;
            for (int k = 0; k < NUM_PORTS; k++) begin
               if (hub_port_rst[k] != 0) begin
                  hub_port_rst[k] = hub_port_rst[k] - 8'd1;
                  if (hub_port_rst[k] == 0) begin
                     was = hub_port[k];
                     hub_port[k] = (was & ~PORT_RESET) | PORT_ENABLE | RESET_DONE_BIT;
                     flag_change(was, hub_port[k]);
                  end
               end
            end
            if (hub_control[7:6] == FUNC_OPER) begin
               hub_fm_number = hub_fm_number + 16'd1;
               hub_int_status |= SOF_BIT;
            end
         end
      end
      r.irq = ((hub_int_enable & IRQ_MASTER) != 0) &&
              ((hub_int_status & hub_int_enable & ~IRQ_MASTER) != 0);
      return r;
   endfunction

   // Random request, weighted toward sequences that reach the root hub logic
   function automatic hub_req_type random_req();
      hub_req_type q;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      q.idx = 6'($urandom_range(0, REG_PORT_BASE + 1));
      if ($urandom_range(0, 9) == 0) q.idx = 6'($urandom_range(0, 63));
      q.wdata = $urandom;
      q.now = {$urandom, $urandom};
      if (pick < 4) begin
         q.cmd = CMD_NOP;
      end else if (pick < 34) begin
         q.cmd = CMD_READ;
      end else if (pick < 70) begin
         q.cmd = CMD_WRITE;
         if (q.idx >= REG_PORT_BASE && $urandom_range(0, 3) != 0)
            q.wdata = $urandom & $urandom & PORT_WRITE_BITS;
         else if (q.idx == REG_CONTROL && $urandom_range(0, 3) != 0)
            q.wdata = {q.wdata[31:8], FUNC_OPER, q.wdata[5:0]};
         else if (q.idx == REG_CMD_STATUS && $urandom_range(0, 3) != 0)
            q.wdata[0] = 1'b0;
      end else begin
         q.cmd = CMD_TICK;
         case ($urandom_range(0, 19))
            0:       tick_base = {$urandom, $urandom};
            1, 2, 3: tick_base += $urandom_range(0, FRAME_TICKS - 1);
            default: tick_base += $urandom_range(FRAME_TICKS - 20, 2 * FRAME_TICKS);
         endcase
         q.now = tick_base;
      end
      return q;
   endfunction

   task automatic push_req(cmd_type c, logic [5:0] i, logic [31:0] d, logic [63:0] t);
      hub_req_type q;
      q.cmd = c;
      q.idx = i;
      q.wdata = d;
      q.now = t;
      add_pending(q);
   endtask

   // Board setup write; the model follows at the accepting edge
   task automatic csr_write(csr_idx_type which, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_write_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (which)
         CSR_PORTS_PRESENT: hub_ports_present = value[1:0];
         CSR_DESC_A_INIT: begin
            hub_desc_a_init = value;
            hub_desc_a = value;
         end
         CSR_DESC_B_INIT: begin
            hub_desc_b_init = value;
            hub_desc_b = value;
         end
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every request is taken and answered, then let the block settle
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || expected_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Request driver: next beat at the falling edge, random gaps unless no_idle is set
   always @(negedge clock) begin
      hub_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
            nxt = pending_q.pop_front();
            req_cmd <= nxt.cmd;
            req_reg_index <= nxt.idx;
            req_write_data <= nxt.wdata;
            req_time_now <= nxt.now;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response sink: random stalls unless no_idle is set, plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Monitor: predict on each accepted request, check each response beat
   always @(posedge clock) begin
      hub_rsp_type want;
      req_taken = !reset && req_valid && req_ready;
      if (req_taken) begin
         case (cmd_type'(req_cmd))
            CMD_READ:  n_reads++;
            CMD_WRITE: n_writes++;
            CMD_TICK:  n_ticks++;
            default: ;
         endcase
         expected_q = {expected_q, predict_response(cmd_type'(req_cmd), req_reg_index,
                                                    req_write_data, req_time_now)};
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected response beat: read_data %h irq_pending %b",
                   rsp_read_data, rsp_irq_pending);
            fail_count++;
         end else begin
            want = expected_q.pop_front();
            rsp_count++;
            if (rsp_read_data !== want.read_data) begin
               $error("read_data mismatch: expected %h actual %h",
                      want.read_data, rsp_read_data);
               fail_count++;
            end
            if (rsp_irq_pending !== want.irq) begin
               $error("irq_pending mismatch: expected %b actual %b",
                      want.irq, rsp_irq_pending);
               fail_count++;
            end
         end
      end
   end

   // Run sequence
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: default board setup, port 0 populated, port 1 empty
      push_req(CMD_READ, REG_REVISION, '0, '0);
      push_req(CMD_READ, REG_RH_DESC_A, '0, '0);
      push_req(CMD_WRITE, REG_CONTROL, {24'd0, FUNC_OPER, 6'd0}, '0);
      push_req(CMD_WRITE, REG_INT_ENABLE, IRQ_MASTER | SOF_BIT | RHSC_BIT, '0);
      push_req(CMD_TICK, REG_REVISION, '0, 64'(FRAME_TICKS));
      push_req(CMD_TICK, REG_REVISION, '0, 64'(2 * FRAME_TICKS - 1));
      push_req(CMD_READ, REG_FM_NUMBER, '0, '0);
      push_req(CMD_WRITE, REG_INT_STATUS, '1, '0);
      push_req(CMD_WRITE, REG_PORT_BASE, PORT_POWER | PORT_ENABLE | PORT_RESET, '0);
      push_req(CMD_WRITE, 6'(REG_PORT_BASE + 1), PORT_ENABLE | PORT_RESET, '0);
      push_req(CMD_WRITE, 6'(REG_PORT_BASE + 2), '1, '0);
      push_req(CMD_READ, 6'(REG_PORT_BASE + 2), '0, '0);
      push_req(CMD_READ, 6'(REG_PORT_BASE + 1), '0, '0);
      push_req(CMD_WRITE, REG_CMD_STATUS, 32'hF, '0);
      push_req(CMD_READ, REG_CONTROL, '0, '0);
      push_req(CMD_READ, REG_CMD_STATUS, '0, '0);
      push_req(CMD_WRITE, REG_HCCA, '1, '0);
      push_req(CMD_READ, REG_HCCA, '0, '0);
      push_req(CMD_WRITE, REG_CTRL_HEAD, '1, '0);
      push_req(CMD_WRITE, REG_FM_INTERVAL, '1, '0);
      push_req(CMD_READ, REG_FM_REMAIN, '0, '0);
      push_req(CMD_WRITE, REG_RH_DESC_A, '1, '0);
      push_req(CMD_READ, REG_RH_DESC_A, '0, '0);
      push_req(CMD_TICK, REG_REVISION, '0, '1);
      push_req(CMD_NOP, 6'h3F, '1, '1);
      push_req(CMD_READ, 6'h3F, '0, '0);
      wait_drained();

      // Both ports populated, descriptor A all ones; no idling on either side
      csr_write(CSR_PORTS_PRESENT, 32'd3);
      csr_write(CSR_DESC_A_INIT, '1);
      csr_write(CSR_DESC_B_INIT, '0);
      csr_write(CSR_UNUSED, $urandom);
      no_idle = 1'b1;
      repeat (250) add_pending(random_req());
      wait_drained();

      // No ports populated; long response hold-off while requests keep coming
      csr_write(CSR_PORTS_PRESENT, 32'd0);
      csr_write(CSR_DESC_A_INIT, '0);
      csr_write(CSR_DESC_B_INIT, '1);
      repeat (250) add_pending(random_req());
      hold_asked++;
      wait_drained();

      // Port 1 only, random descriptors, random idling again
      csr_write(CSR_PORTS_PRESENT, 32'd2);
      csr_write(CSR_DESC_A_INIT, $urandom);
      csr_write(CSR_DESC_B_INIT, $urandom);
      no_idle = 1'b0;
      repeat (500) add_pending(random_req());
      wait_drained();

      $display("tb: %0d responses checked: %0d reads, %0d writes, %0d ticks (%0d frames taken)",
               rsp_count, n_reads, n_writes, n_ticks, n_frames);
      $display("tb: four board setups, one long response stall, %0d errors", fail_count);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/usbhrh_pkg.sv
hw/rtl/usb_host_controller_root_hub_regs_unit.sv
hw/rtl/usbhrh_checker.sv
tb/usb_host_controller_root_hub_regs_unit_tb.sv
